FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the sequencer RTL.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Checks that a condition in one cycle implies another condition in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/ftss_pkg.sv
// Shared constants, types and register codes for the four-row step sequencer.
// Used by the row lane, the output stage and the top level; depends on nothing.
package ftss_pkg;

	localparam int ROWS        = 4;
	localparam int STEPS       = 16;
	localparam int POS_W       = 5;
	localparam int IDX_W       = $clog2(STEPS);
	localparam int LEN_W       = 5;
	localparam int WIN_W       = 8;
	localparam int MUTE_W      = 2 * ROWS;
	localparam int PAT_W       = 2 * STEPS;
	localparam int LENS_W      = LEN_W * ROWS;
	localparam int CFG_W       = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int HOLD_W      = 5;
	localparam int HOLD_TICKS  = 20;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 32;

	localparam int IN_CLK_LO   = 0;
	localparam int IN_RUN_LO   = ROWS;
	localparam int IN_RST_LO   = 2 * ROWS;
	localparam int OUT_UP_LO   = 0;
	localparam int OUT_LOW_LO  = ROWS;
	localparam int OUT_POS_LO  = 2 * ROWS;

	localparam logic [PAT_W-1:0]  PATTERN_RESET = 32'h5555_5555;
	localparam logic [LENS_W-1:0] LENGTHS_RESET = 20'd541200;
	localparam logic [MUTE_W-1:0] MUTE_RESET    = 8'd0;
	localparam logic [WIN_W-1:0]  WINDOW_RESET  = 8'd5;

	localparam logic [1:0] SET_LOWER = 2'd0;
	localparam logic [1:0] SET_UPPER = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN0 = 3'd0,
		REG_PATTERN1 = 3'd1,
		REG_PATTERN2 = 3'd2,
		REG_PATTERN3 = 3'd3,
		REG_LENGTHS  = 3'd4,
		REG_MUTE     = 3'd5,
		REG_WINDOW   = 3'd6
	} cfg_reg_e;

	typedef logic [STEPS-1:0][1:0] pattern_t;

	typedef struct packed {
		pattern_t          pattern;
		logic [LEN_W-1:0]  len_field;
		logic              mute_upper;
		logic              mute_lower;
		logic [WIN_W-1:0]  window;
	} lane_cfg_t;

	typedef struct packed {
		logic clk_edge;
		logic run_edge;
		logic rst_edge;
		logic run_high;
		logic clock_high;
	} lane_in_t;

	typedef struct packed {
		logic             upper;
		logic             lower;
		logic [POS_W-1:0] pos;
	} lane_out_t;

endpackage

FILE: rtl/core/ftss_lane.sv
// One row of the sequencer: step position, coincidence window and run flag.
// Depends on ftss_pkg; the top level instantiates one lane per row.
module ftss_lane import ftss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  lane_cfg_t cfg,
	input  lane_in_t  lin,
	output lane_out_t lout
);

	logic [POS_W-1:0] pos_q;
	logic [WIN_W-1:0] win_q;
	logic             running_q;

	logic [POS_W-1:0] len;
	logic [POS_W-1:0] pos_base;
	logic [POS_W-1:0] pos_inc;
	logic [POS_W-1:0] pos_d;
	logic [POS_W-1:0] pos_m1;
	logic [WIN_W-1:0] win_d;
	logic             adv;
	logic             running_d;
	logic             gate_ok;
	logic [1:0]       setting;

	always_comb begin
		if (cfg.len_field == '0) begin
			len = POS_W'(1);
		end else if (cfg.len_field > POS_W'(STEPS)) begin
			len = POS_W'(STEPS);
		end else begin
			len = cfg.len_field;
		end

		pos_base = lin.rst_edge ? '0 : pos_q;
		pos_inc  = pos_base + 1'b1;

		adv   = 1'b0;
		win_d = win_q;
		if (lin.clk_edge) begin
			win_d = cfg.window;
			adv   = 1'b1;
		end else if (win_q != '0) begin
			win_d = win_q - 1'b1;
			adv   = lin.run_edge | lin.rst_edge;
		end

		running_d = lin.run_high & (running_q | adv);

		pos_d = pos_base;
		if (adv && lin.run_high) begin
			pos_d = (pos_inc > len) ? POS_W'(1) : pos_inc;
		end

		pos_m1  = pos_d - 1'b1;
		setting = cfg.pattern[pos_m1[IDX_W-1:0]];
		gate_ok = running_d & lin.clock_high & (pos_d != '0);

		lout.upper = gate_ok & (setting == SET_UPPER) & ~cfg.mute_upper;
		lout.lower = gate_ok & (setting == SET_LOWER) & ~cfg.mute_lower;
		lout.pos   = pos_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			win_q     <= '0;
			running_q <= 1'b0;
		end else if (fire) begin
			pos_q     <= pos_d;
			win_q     <= win_d;
			running_q <= running_d;
		end
	end

endmodule

FILE: rtl/core/ftss_merge.sv
// Output stage: gathers the per-row results into one beat and holds it for the sink.
// Depends on ftss_pkg; driven by the row lanes in the top level.
module ftss_merge import ftss_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  lane_out_t              lanes [ROWS],
	input  logic                   m_axis_tready,
	output logic                   m_axis_tvalid,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   in_ready
);

	logic                   valid_q;
	logic [OUT_TDATA_W-1:0] data_q;
	logic [OUT_TDATA_W-1:0] packed_d;

	always_comb begin
		packed_d = '0;
		for (int r = 0; r < ROWS; r++) begin
			packed_d[OUT_UP_LO + r]                = lanes[r].upper;
			packed_d[OUT_LOW_LO + r]               = lanes[r].lower;
			packed_d[OUT_POS_LO + POS_W * r +: POS_W] = lanes[r].pos;
		end
	end

	assign in_ready      = ~valid_q | m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			data_q <= packed_d;
		end
	end

endmodule

FILE: rtl/core/four_row_trigger_step_sequencer_top.sv
// Four-row trigger step sequencer, top level: config registers, edge detection, lanes.
// Depends on ftss_pkg, ftss_lane, ftss_merge and assert_macros.svh.
//
// Each input beat is one tick of clock, run and reset levels for four rows and yields
// exactly one output beat with the gate levels and step positions after that tick. The
// block takes one beat per cycle and answers in the next cycle from a registered output
// stage; while that stage holds a beat the sink has not taken, input is accepted only in
// the cycle the sink takes it. Row state lives in four lanes that update in parallel, so
// throughput is set by the single output register. For the first 19 input beats after
// reset the clock and run levels are ignored. Config writes apply to later input beats.
module four_row_trigger_step_sequencer_top import ftss_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// Fields from bit 0: clock_levels[3:0], run_levels[7:4], reset_levels[11:8], zero pad.
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// Fields from bit 0: upper_gates[3:0], lower_gates[7:4], position_row_zero[12:8],
	// position_row_one[17:13], position_row_two[22:18], position_row_three[27:23], pad.
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	`include "assert_macros.svh"

	logic [PAT_W-1:0]  pattern_q [ROWS];
	logic [LENS_W-1:0] lengths_q;
	logic [MUTE_W-1:0] mute_q;
	logic [WIN_W-1:0]  window_q;

	logic [ROWS-1:0]   clock_last_q;
	logic [ROWS-1:0]   run_last_q;
	logic [ROWS-1:0]   reset_last_q;
	logic [HOLD_W-1:0] hold_q;

	logic [ROWS-1:0]   clk_in;
	logic [ROWS-1:0]   run_in;
	logic [ROWS-1:0]   rst_in;
	logic [HOLD_W-1:0] hold_d;
	logic              hold_active;
	logic [ROWS-1:0]   clock_last_d;
	logic [ROWS-1:0]   run_last_d;
	logic [ROWS-1:0]   clk_edge;
	logic [ROWS-1:0]   run_edge;
	logic [ROWS-1:0]   rst_edge;
	logic              fire;
	logic              in_ready;

	lane_cfg_t lane_cfg [ROWS];
	lane_in_t  lane_in  [ROWS];
	lane_out_t lane_out [ROWS];

	assign s_axis_tready = in_ready;
	assign fire          = s_axis_tvalid & in_ready;

	assign clk_in = s_axis_tdata[IN_CLK_LO +: ROWS];
	assign run_in = s_axis_tdata[IN_RUN_LO +: ROWS];
	assign rst_in = s_axis_tdata[IN_RST_LO +: ROWS];

	always_comb begin
		hold_d       = (hold_q != '0) ? hold_q - 1'b1 : hold_q;
		hold_active  = (hold_d != '0);
		clock_last_d = hold_active ? clock_last_q : clk_in;
		run_last_d   = hold_active ? run_last_q : run_in;
		clk_edge     = hold_active ? '0 : (clk_in & ~clock_last_q);
		run_edge     = hold_active ? '0 : (run_in & ~run_last_q);
		rst_edge     = rst_in & ~reset_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_last_q <= '0;
			run_last_q   <= '0;
			reset_last_q <= '0;
			hold_q       <= HOLD_W'(HOLD_TICKS);
		end else if (fire) begin
			clock_last_q <= clock_last_d;
			run_last_q   <= run_last_d;
			reset_last_q <= rst_in;
			hold_q       <= hold_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				pattern_q[r] <= PATTERN_RESET;
			end
			lengths_q <= LENGTHS_RESET;
			mute_q    <= MUTE_RESET;
			window_q  <= WINDOW_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_e'(cfg_index))
				REG_PATTERN0: begin
					pattern_q[0] <= cfg_data[PAT_W-1:0];
				end
				REG_PATTERN1: begin
					pattern_q[1] <= cfg_data[PAT_W-1:0];
				end
				REG_PATTERN2: begin
					pattern_q[2] <= cfg_data[PAT_W-1:0];
				end
				REG_PATTERN3: begin
					pattern_q[3] <= cfg_data[PAT_W-1:0];
				end
				REG_LENGTHS: begin
					lengths_q <= cfg_data[LENS_W-1:0];
				end
				REG_MUTE: begin
					mute_q <= cfg_data[MUTE_W-1:0];
				end
				REG_WINDOW: begin
					window_q <= cfg_data[WIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	for (genvar r = 0; r < ROWS; r++) begin : g_lane
		always_comb begin
			lane_cfg[r].pattern    = pattern_t'(pattern_q[r]);
			lane_cfg[r].len_field  = lengths_q[LEN_W * r +: LEN_W];
			lane_cfg[r].mute_upper = mute_q[2 * r];
			lane_cfg[r].mute_lower = mute_q[2 * r + 1];
			lane_cfg[r].window     = window_q;

			lane_in[r].clk_edge   = clk_edge[r];
			lane_in[r].run_edge   = run_edge[r];
			lane_in[r].rst_edge   = rst_edge[r];
			lane_in[r].run_high   = run_last_d[r];
			lane_in[r].clock_high = clock_last_d[r];
		end

		ftss_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.fire   (fire),
			.cfg    (lane_cfg[r]),
			.lin    (lane_in[r]),
			.lout   (lane_out[r])
		);
	end

	ftss_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.lanes         (lane_out),
		.m_axis_tready (m_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tdata  (m_axis_tdata),
		.in_ready      (in_ready)
	);

	`ASSERT_NEXT(a_beat_follows_accept, fire, m_axis_tvalid, "accepted beat gave no output beat")
	`ASSERT_ALWAYS(a_one_gate_per_row, (!m_axis_tvalid || ((m_axis_tdata[OUT_UP_LO +: ROWS] & m_axis_tdata[OUT_LOW_LO +: ROWS]) == '0)), "upper and lower gate open together")
	`ASSERT_ALWAYS(a_pos_in_range, (!m_axis_tvalid || ((m_axis_tdata[12:8] <= POS_W'(STEPS)) && (m_axis_tdata[17:13] <= POS_W'(STEPS)) && (m_axis_tdata[22:18] <= POS_W'(STEPS)) && (m_axis_tdata[27:23] <= POS_W'(STEPS)))), "step position beyond last step")
	`ASSERT_NEXT(a_gates_closed_in_hold, (fire && (hold_q > HOLD_W'(1))), (m_axis_tdata[2*ROWS-1:0] == '0), "gate opened during startup hold")

endmodule
